@@ rtl/rpbu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbu_pkg
// Shared types, mode codes and 8-bit pixel arithmetic for the blend unit.
// ----------------------------------------------------------------------------
package rpbu_pkg;

    localparam int CW = 8;   // channel width
    localparam int NW = 16;  // divider dividend width
    localparam int QW = 8;   // quotient width, one bit per divider stage

    localparam logic [4:0] MODE_SRC        = 5'd0;
    localparam logic [4:0] MODE_MERGE      = 5'd1;
    localparam logic [4:0] MODE_DST_OVER   = 5'd2;
    localparam logic [4:0] MODE_NORMAL     = 5'd3;
    localparam logic [4:0] MODE_MULTIPLY   = 5'd4;
    localparam logic [4:0] MODE_SCREEN     = 5'd5;
    localparam logic [4:0] MODE_OVERLAY    = 5'd6;
    localparam logic [4:0] MODE_DARKEN     = 5'd7;
    localparam logic [4:0] MODE_LIGHTEN    = 5'd8;
    localparam logic [4:0] MODE_DODGE      = 5'd9;
    localparam logic [4:0] MODE_BURN       = 5'd10;
    localparam logic [4:0] MODE_HARD_LIGHT = 5'd11;
    localparam logic [4:0] MODE_DIFFERENCE = 5'd12;
    localparam logic [4:0] MODE_EXCLUSION  = 5'd13;
    localparam logic [4:0] MODE_ADDITION   = 5'd14;
    localparam logic [4:0] MODE_SUBTRACT   = 5'd15;
    localparam logic [4:0] MODE_DIVIDE     = 5'd16;

    localparam logic [1:0] REG_BLEND_MODE    = 2'd0;
    localparam logic [1:0] REG_LAYER_OPACITY = 2'd1;
    localparam logic [1:0] REG_NEW_COMPOSITE = 2'd2;

    localparam logic [4:0] RST_BLEND_MODE    = MODE_NORMAL;
    localparam logic [7:0] RST_LAYER_OPACITY = 8'd255;
    localparam logic       RST_NEW_COMPOSITE = 1'b0;

    typedef struct packed {
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
        logic [7:0] back_alpha;
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } out_word_t;

    // c[0] red, c[1] green, c[2] blue
    typedef struct packed {
        logic [2:0][CW-1:0] c;
        logic [CW-1:0]      a;
    } pix_t;

    typedef struct packed {
        logic [4:0]    mode;
        logic [CW-1:0] opacity;
        logic          new_comp;
    } cfg_t;

    typedef struct packed {
        logic          use_div;
        logic          inv;
        logic [CW-1:0] val;
        logic [NW-1:0] num;
        logic [CW-1:0] den;
    } chan_t;

    // Everything one pixel carries down the pipe.
    typedef struct packed {
        pix_t               bk;       // backdrop
        pix_t               sr;       // source
        pix_t               bn;       // backdrop of the primary source-over
        logic [2:0][CW-1:0] sn;       // source colors of the primary source-over
        logic [CW-1:0]      san;      // scaled source alpha
        logic [2:0]         use_div;
        logic [2:0]         inv;
        logic [2:0][CW-1:0] cval;     // blend value when no divide is needed
        logic [2:0][CW-1:0] m;        // blended colors
        logic [CW-1:0]      ra;       // result alpha
        logic [CW-1:0]      comp;     // backdrop alpha times scaled source alpha
        logic [5:0]         neg;      // quotient signs
        pix_t               n1;       // plain source-over result
        pix_t               n2;       // blended source-over result
        pix_t               g;        // first merge result
    } work_t;

    // a*b/255 rounded
    function automatic logic [CW-1:0] mul8u(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [16:0] t;
        logic [17:0] u;
        t = 17'(a) * 17'(b) + 17'd128;
        u = {9'b0, t[16:8]} + {1'b0, t};
        return u[15:8];
    endfunction

    // signed difference times opacity over 255, floor shifts
    function automatic logic signed [8:0] mul8s(input logic signed [8:0] d,
                                                input logic [CW-1:0] op);
        logic signed [18:0] t;
        logic signed [18:0] u;
        t = $signed({{10{d[8]}}, d}) * $signed({11'b0, op}) + 19'sd128;
        u = (t >>> 8) + t;
        return u[16:8];
    endfunction

    function automatic pix_t merge_px(input pix_t b, input pix_t s, input logic [CW-1:0] op);
        pix_t            r;
        logic signed [8:0] d;
        logic signed [8:0] k;
        for (int i = 0; i < 3; i++) begin
            d = $signed({1'b0, s.c[i]}) - $signed({1'b0, b.c[i]});
            k = mul8s(d, op);
            if (b.a == '0)
                r.c[i] = s.c[i];
            else if (s.a == '0)
                r.c[i] = b.c[i];
            else
                r.c[i] = b.c[i] + k[7:0];
        end
        d = $signed({1'b0, s.a}) - $signed({1'b0, b.a});
        k = mul8s(d, op);
        r.a = b.a + k[7:0];
        if (r.a == '0)
            r.c = '0;
        return r;
    endfunction

    // a*255 + den/2, dividend of a rounded a*255/den
    function automatic logic [NW-1:0] div_num(input logic [CW-1:0] a, input logic [CW-1:0] den);
        return ({a, 8'h00} - {8'h00, a}) + {9'b0, den[7:1]};
    endfunction

    // Per-channel blend value, or the divide it still needs.
    function automatic chan_t chan_prep(input logic [4:0] mode, input logic [CW-1:0] b,
                                        input logic [CW-1:0] s);
        chan_t         r;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] yy;
        logic [CW-1:0] p;
        logic [CW-1:0] inv_s;
        logic [CW-1:0] inv_b;
        logic [CW:0]   sum;
        r       = '0;
        r.den   = 8'd1;
        x       = (mode == MODE_OVERLAY) ? s : b;
        y       = (mode == MODE_OVERLAY) ? b : s;
        // hard light: 2y for the multiply half, 2y-255 for the screen half
        yy      = (mode == MODE_OVERLAY || mode == MODE_HARD_LIGHT) ? {y[6:0], y[7]} : y;
        p       = mul8u(x, yy);
        inv_s   = ~s;
        inv_b   = ~b;
        sum     = {1'b0, b} + {1'b0, s};
        case (mode)
            MODE_MULTIPLY:   r.val = p;
            MODE_SCREEN:     r.val = b + s - p;
            MODE_OVERLAY,
            MODE_HARD_LIGHT: r.val = y[7] ? (x + yy - p) : p;
            MODE_DARKEN:     r.val = (b < s) ? b : s;
            MODE_LIGHTEN:    r.val = (b > s) ? b : s;
            MODE_DODGE: begin
                if (b == '0)
                    r.val = '0;
                else if (b >= inv_s)
                    r.val = 8'd255;
                else begin
                    r.use_div = 1'b1;
                    r.num     = div_num(b, inv_s);
                    r.den     = inv_s;
                end
            end
            MODE_BURN: begin
                if (b == 8'd255)
                    r.val = 8'd255;
                else if (inv_b >= s)
                    r.val = '0;
                else begin
                    r.use_div = 1'b1;
                    r.inv     = 1'b1;
                    r.num     = div_num(inv_b, s);
                    r.den     = s;
                end
            end
            MODE_DIFFERENCE: r.val = (b > s) ? (b - s) : (s - b);
            MODE_EXCLUSION:  r.val = b + s - {p[6:0], 1'b0};
            MODE_ADDITION:   r.val = sum[8] ? 8'd255 : sum[7:0];
            MODE_SUBTRACT:   r.val = (b >= s) ? (b - s) : 8'd0;
            MODE_DIVIDE: begin
                if (b == '0)
                    r.val = '0;
                else if (b >= s)
                    r.val = 8'd255;
                else begin
                    r.use_div = 1'b1;
                    r.num     = div_num(b, s);
                    r.den     = s;
                end
            end
            default: r.val = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/rpbu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbu_div
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// ----------------------------------------------------------------------------
module rpbu_div #(
    parameter int LANES = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  rpbu_pkg::work_t                       in_work,
    input  logic [LANES-1:0][rpbu_pkg::NW-1:0]    in_num,
    input  logic [LANES-1:0][rpbu_pkg::CW-1:0]    in_den,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output rpbu_pkg::work_t                       out_work,
    output logic [LANES-1:0][rpbu_pkg::QW-1:0]    out_quo
);
    import rpbu_pkg::*;

    localparam int STAGES = QW;

    logic                       valid_reg [STAGES];
    work_t                      work_reg  [STAGES];
    logic [LANES-1:0][NW-1:0]   rem_reg   [STAGES];
    logic [LANES-1:0][CW-1:0]   den_reg   [STAGES];
    logic [LANES-1:0][QW-1:0]   quo_reg   [STAGES];
    logic [STAGES:0]            rdy;

    always_comb begin
        rdy[STAGES] = out_ready;
        for (int s = STAGES - 1; s >= 0; s--)
            rdy[s] = !valid_reg[s] || rdy[s+1];
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_work  = work_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int BIT = STAGES - 1 - s;

        logic                     pv;
        work_t                    pw;
        logic [LANES-1:0][NW-1:0] pr;
        logic [LANES-1:0][CW-1:0] pd;
        logic [LANES-1:0][QW-1:0] pq;
        logic [LANES-1:0][NW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] quo_next;

        if (s == 0) begin : g_head
            assign pv = in_valid;
            assign pw = in_work;
            assign pr = in_num;
            assign pd = in_den;
            assign pq = '0;
        end else begin : g_body
            assign pv = valid_reg[s-1];
            assign pw = work_reg[s-1];
            assign pr = rem_reg[s-1];
            assign pd = den_reg[s-1];
            assign pq = quo_reg[s-1];
        end

        always_comb begin
            logic [NW-1:0] sh;
            for (int l = 0; l < LANES; l++) begin
                sh = NW'(pd[l]) << BIT;
                if (pr[l] >= sh) begin
                    rem_next[l] = pr[l] - sh;
                    quo_next[l] = {pq[l][QW-2:0], 1'b1};
                end else begin
                    rem_next[l] = pr[l];
                    quo_next[l] = {pq[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (rdy[s])
                valid_reg[s] <= pv;
        end

        always_ff @(posedge clk) begin
            if (rdy[s] && pv) begin
                work_reg[s] <= pw;
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= pd;
                quo_reg[s]  <= quo_next;
            end
        end
    end

    logic num_fits;
    logic rem_done;

    always_comb begin
        num_fits = 1'b1;
        rem_done = 1'b1;
        for (int l = 0; l < LANES; l++) begin
            if (in_den[l] == '0 || in_num[l] >= {in_den[l], 8'h00})
                num_fits = 1'b0;
            if (rem_reg[STAGES-1][l] >= NW'(den_reg[STAGES-1][l]))
                rem_done = 1'b0;
        end
    end

    // quotient must fit in QW bits
    a_num_fits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> num_fits)
        else $error("divider dividend too large for quotient width");

    a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES-1] |-> rem_done)
        else $error("divider remainder not below divisor");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_quo)))
        else $error("divider output changed while stalled");

endmodule

@@ rtl/rpbu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbu_front
// Input stage: unpacks the word, scales source alpha, prepares blend values.
// ----------------------------------------------------------------------------
module rpbu_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rpbu_pkg::in_word_t             in_word,
    input  rpbu_pkg::cfg_t                 cfg,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rpbu_pkg::work_t                out_work,
    output logic [2:0][rpbu_pkg::NW-1:0]   out_num,
    output logic [2:0][rpbu_pkg::CW-1:0]   out_den
);
    import rpbu_pkg::*;

    logic               valid_reg;
    work_t              work_reg, work_next;
    logic [2:0][NW-1:0] num_reg, num_next;
    logic [2:0][CW-1:0] den_reg, den_next;
    pix_t               bk, sr;
    logic [CW-1:0]      sa_op;
    chan_t              ch [3];

    always_comb begin
        bk.c[0] = in_word.back_red;
        bk.c[1] = in_word.back_green;
        bk.c[2] = in_word.back_blue;
        bk.a    = in_word.back_alpha;
        sr.c[0] = in_word.src_red;
        sr.c[1] = in_word.src_green;
        sr.c[2] = in_word.src_blue;
        sr.a    = in_word.src_alpha;
        sa_op   = mul8u(sr.a, cfg.opacity);

        work_next    = '0;
        work_next.bk = bk;
        work_next.sr = sr;
        // dst-over: backdrop goes over the opacity-scaled source
        if (cfg.mode == MODE_DST_OVER) begin
            work_next.bn.c = sr.c;
            work_next.bn.a = sa_op;
            work_next.sn   = bk.c;
            work_next.san  = bk.a;
        end else begin
            work_next.bn  = bk;
            work_next.sn  = sr.c;
            work_next.san = sa_op;
        end

        for (int i = 0; i < 3; i++) begin
            ch[i]                = chan_prep(cfg.mode, bk.c[i], sr.c[i]);
            work_next.use_div[i] = ch[i].use_div;
            work_next.inv[i]     = ch[i].inv;
            work_next.cval[i]    = ch[i].val;
            num_next[i]          = ch[i].num;
            den_next[i]          = ch[i].den;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

endmodule

@@ rtl/rpbu_mid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbu_mid
// Two stages: blended colors and result alpha, then the source-over dividends.
// ----------------------------------------------------------------------------
module rpbu_mid (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rpbu_pkg::work_t                in_work,
    input  logic [2:0][rpbu_pkg::QW-1:0]   in_quo,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rpbu_pkg::work_t                out_work,
    output logic [5:0][rpbu_pkg::NW-1:0]   out_num,
    output logic [5:0][rpbu_pkg::CW-1:0]   out_den
);
    import rpbu_pkg::*;

    logic               a_valid_reg, b_valid_reg;
    work_t              a_work_reg, a_work_next;
    work_t              b_work_reg, b_work_next;
    logic [5:0][NW-1:0] num_reg, num_next;
    logic [CW-1:0]      den_reg, den_next;
    logic               a_rdy, b_rdy;

    assign b_rdy    = !b_valid_reg || out_ready;
    assign a_rdy    = !a_valid_reg || b_rdy;
    assign in_ready = a_rdy;

    // stage A: blend colors, ra = Sa + Ba - Ba*Sa
    always_comb begin
        logic [CW-1:0] pm;
        logic [CW:0]   ra_w;
        a_work_next = in_work;
        for (int i = 0; i < 3; i++) begin
            if (in_work.use_div[i])
                a_work_next.m[i] = in_work.inv[i] ? ~in_quo[i] : in_quo[i];
            else
                a_work_next.m[i] = in_work.cval[i];
        end
        pm   = mul8u(in_work.bn.a, in_work.san);
        ra_w = {1'b0, in_work.san} + {1'b0, in_work.bn.a} - {1'b0, pm};
        a_work_next.ra   = ra_w[CW-1:0];
        a_work_next.comp = pm;
    end

    // stage B: |S-B| * Sa for plain (lanes 0..2) and blended (3..5) colors
    always_comb begin
        logic signed [8:0] d;
        logic [8:0]        mag;
        b_work_next = a_work_reg;
        for (int l = 0; l < 6; l++) begin
            if (l < 3)
                d = $signed({1'b0, a_work_reg.sn[l]}) - $signed({1'b0, a_work_reg.bn.c[l]});
            else
                d = $signed({1'b0, a_work_reg.m[l-3]}) - $signed({1'b0, a_work_reg.bn.c[l-3]});
            mag                = d[8] ? 9'(-d) : 9'(d);
            b_work_next.neg[l] = d[8];
            num_next[l]        = NW'(mag[CW-1:0]) * NW'(a_work_reg.san);
        end
        den_next = (a_work_reg.ra == '0) ? 8'd1 : a_work_reg.ra;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_rdy)
                a_valid_reg <= in_valid;
            if (b_rdy)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (a_rdy && in_valid)
            a_work_reg <= a_work_next;
        if (b_rdy && a_valid_reg) begin
            b_work_reg <= b_work_next;
            num_reg    <= num_next;
            den_reg    <= den_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_work  = b_work_reg;
    assign out_num   = num_reg;
    assign out_den   = {6{den_reg}};

endmodule

@@ rtl/rpbu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbu_back
// Source-over results, the merge stages and the output register.
// ----------------------------------------------------------------------------
module rpbu_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rpbu_pkg::work_t                in_work,
    input  logic [5:0][rpbu_pkg::QW-1:0]   in_quo,
    input  rpbu_pkg::cfg_t                 cfg,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rpbu_pkg::out_word_t            out_word
);
    import rpbu_pkg::*;

    logic      f_valid_reg, g_valid_reg, h_valid_reg;
    work_t     f_work_reg, f_work_next;
    work_t     g_work_reg, g_work_next;
    out_word_t out_word_reg, out_word_next;
    logic      f_rdy, g_rdy, h_rdy;
    logic      sep_mode;

    assign h_rdy    = !h_valid_reg || out_ready;
    assign g_rdy    = !g_valid_reg || h_rdy;
    assign f_rdy    = !f_valid_reg || g_rdy;
    assign in_ready = f_rdy;
    assign sep_mode = cfg.mode inside {[MODE_MULTIPLY:MODE_DIVIDE]};

    // stage F: B + signed quotient, transparent backdrop takes the source
    always_comb begin
        logic [CW-1:0] alpha;
        f_work_next = in_work;
        alpha       = (in_work.bn.a == '0) ? in_work.san : in_work.ra;
        for (int i = 0; i < 3; i++) begin
            if (in_work.bn.a == '0) begin
                f_work_next.n1.c[i] = in_work.sn[i];
                f_work_next.n2.c[i] = in_work.m[i];
            end else begin
                f_work_next.n1.c[i] = in_work.neg[i] ? in_work.bn.c[i] - in_quo[i]
                                                     : in_work.bn.c[i] + in_quo[i];
                f_work_next.n2.c[i] = in_work.neg[i+3] ? in_work.bn.c[i] - in_quo[i+3]
                                                       : in_work.bn.c[i] + in_quo[i+3];
            end
        end
        f_work_next.n1.a = alpha;
        f_work_next.n2.a = alpha;
    end

    // stage G: merge mode, or plain result mixed toward blend by backdrop alpha
    always_comb begin
        g_work_next = f_work_reg;
        if (cfg.mode == MODE_MERGE)
            g_work_next.g = merge_px(f_work_reg.bk, f_work_reg.sr, cfg.opacity);
        else
            g_work_next.g = merge_px(f_work_reg.n1, f_work_reg.n2, f_work_reg.bk.a);
    end

    // stage H: final select
    always_comb begin
        pix_t res;
        pix_t fin;
        fin = merge_px(g_work_reg.g, g_work_reg.n2, g_work_reg.comp);
        if (cfg.mode == MODE_SRC)
            res = g_work_reg.sr;
        else if (cfg.mode == MODE_MERGE)
            res = g_work_reg.g;
        else if (sep_mode) begin
            if (!cfg.new_comp)
                res = g_work_reg.n2;
            else if (g_work_reg.bk.a != '0)
                res = fin;
            else
                res = g_work_reg.n1;
        end else
            res = g_work_reg.n1;
        out_word_next.out_red   = res.c[0];
        out_word_next.out_green = res.c[1];
        out_word_next.out_blue  = res.c[2];
        out_word_next.out_alpha = res.a;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end else begin
            if (f_rdy)
                f_valid_reg <= in_valid;
            if (g_rdy)
                g_valid_reg <= f_valid_reg;
            if (h_rdy)
                h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (f_rdy && in_valid)
            f_work_reg <= f_work_next;
        if (g_rdy && f_valid_reg)
            g_work_reg <= g_work_next;
        if (h_rdy && g_valid_reg)
            out_word_reg <= out_word_next;
    end

    assign out_valid = h_valid_reg;
    assign out_word  = out_word_reg;

endmodule

@@ rtl/rgba_pixel_blend_unit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_pixel_blend_unit_top
// RGBA8 blend: src, merge, dst-over, source-over and separable blend modes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              word
//  in        input      in_valid / in_ready    in_word_t: backdrop + source
//  out       output     out_valid / out_ready  out_word_t: blended pixel
//  cfg       input      cfg_wr_en              cfg_index, cfg_data
//
//  One pixel per clock sustained while out_ready stays high.
//  The pipe is built from the two 8-stage dividers (blend divide, then the
//  source-over divide by result alpha) plus six arithmetic stages.
//  Reset clears all stage valid bits and loads mode normal, opacity 255,
//  classic composite. Every stage holds its word while the next is full
//  and cannot take it; a stalled output backs the pipe up until every stage is full.
// ----------------------------------------------------------------------------
module rgba_pixel_blend_unit_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rpbu_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rpbu_pkg::out_word_t  out_word,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data
);
    import rpbu_pkg::*;

    // configuration registers
    logic [4:0]    mode_reg;
    logic [CW-1:0] opacity_reg;
    logic          new_comp_reg;
    cfg_t          cfg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg     <= RST_BLEND_MODE;
            opacity_reg  <= RST_LAYER_OPACITY;
            new_comp_reg <= RST_NEW_COMPOSITE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BLEND_MODE:    mode_reg     <= cfg_data[4:0];
                REG_LAYER_OPACITY: opacity_reg  <= cfg_data;
                REG_NEW_COMPOSITE: new_comp_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg.mode     = mode_reg;
    assign cfg.opacity  = opacity_reg;
    assign cfg.new_comp = new_comp_reg;

    // stage wiring: front -> blend divider -> mid -> over divider -> back
    logic               fr_valid, fr_ready;
    work_t              fr_work;
    logic [2:0][NW-1:0] fr_num;
    logic [2:0][CW-1:0] fr_den;

    logic               da_valid, da_ready;
    work_t              da_work;
    logic [2:0][QW-1:0] da_quo;

    logic               md_valid, md_ready;
    work_t              md_work;
    logic [5:0][NW-1:0] md_num;
    logic [5:0][CW-1:0] md_den;

    logic               db_valid, db_ready;
    work_t              db_work;
    logic [5:0][QW-1:0] db_quo;

    rpbu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .cfg       (cfg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_work  (fr_work),
        .out_num   (fr_num),
        .out_den   (fr_den)
    );

    // dodge, burn and divide quotients
    rpbu_div #(
        .LANES (3)
    ) u_div_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_work   (fr_work),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .out_valid (da_valid),
        .out_ready (da_ready),
        .out_work  (da_work),
        .out_quo   (da_quo)
    );

    rpbu_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (da_valid),
        .in_ready  (da_ready),
        .in_work   (da_work),
        .in_quo    (da_quo),
        .out_valid (md_valid),
        .out_ready (md_ready),
        .out_work  (md_work),
        .out_num   (md_num),
        .out_den   (md_den)
    );

    // (S-B)*Sa / Ra for plain and blended colors
    rpbu_div #(
        .LANES (6)
    ) u_div_over (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (md_valid),
        .in_ready  (md_ready),
        .in_work   (md_work),
        .in_num    (md_num),
        .in_den    (md_den),
        .out_valid (db_valid),
        .out_ready (db_ready),
        .out_work  (db_work),
        .out_quo   (db_quo)
    );

    rpbu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (db_valid),
        .in_ready  (db_ready),
        .in_work   (db_work),
        .in_quo    (db_quo),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // input only backs up when every stage is full and the output is stalled
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while pipeline has room");

    // a stalled output word stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_word))
        else $error("output word changed while stalled");

endmodule

@@ tb/rgba_pixel_blend_unit_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_pixel_blend_unit_top_tb
// Drives backdrop/source pixel pairs through the blend unit under every mode
// and composite style at varied opacities, predicts each blended pixel in the
// bench and checks the output stream in order, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module rgba_pixel_blend_unit_top_tb;
    import rpbu_pkg::*;

    // Pixel held as signed ints so the merge math can go negative.
    typedef struct {
        int r;
        int g;
        int b;
        int a;
    } rgba_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;
    logic      cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // bench copy of the registers
    logic [4:0] cur_mode = RST_BLEND_MODE;
    logic [7:0] cur_opacity = RST_LAYER_OPACITY;
    logic       cur_new = RST_NEW_COMPOSITE;

    out_word_t  pending_pixels[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         stall_left = 0;
    bit         timed_out = 1'b0;
    localparam int WATCHDOG = 20000;

    rgba_pixel_blend_unit_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------- math
    function automatic int floor256(int v);
        if (v >= 0)
            return v / 256;
        return -((-v + 255) / 256);
    endfunction

    // rounded a*b/255, valid for negative a too (floor shifts)
    function automatic int scale255(int a, int b);
        int t;
        t = a * b + 128;
        return floor256(floor256(t) + t);
    endfunction

    function automatic int ratio255(int a, int b);
        if (b <= 0)
            return 255;
        return (a * 255 + b / 2) / b;
    endfunction

    // source-over; SV '/' on ints truncates toward zero like the spec asks
    function automatic rgba_t source_over(rgba_t bk, rgba_t sr, int op);
        rgba_t r;
        int sa;
        int ra;
        if (bk.a == 0)
        begin
            r = sr;
            r.a = scale255(sr.a, op);
            return r;
        end
        if (sr.a == 0)
            return bk;
        sa = scale255(sr.a, op);
        ra = sa + bk.a - scale255(bk.a, sa);
        if (ra <= 0)
            ra = 1;
        r.r = bk.r + (sr.r - bk.r) * sa / ra;
        r.g = bk.g + (sr.g - bk.g) * sa / ra;
        r.b = bk.b + (sr.b - bk.b) * sa / ra;
        r.a = ra;
        return r;
    endfunction

    function automatic rgba_t merge_pixels(rgba_t bk, rgba_t sr, int op);
        rgba_t r;
        if (bk.a == 0)
        begin
            r.r = sr.r; r.g = sr.g; r.b = sr.b;
        end
        else if (sr.a == 0)
        begin
            r.r = bk.r; r.g = bk.g; r.b = bk.b;
        end
        else
        begin
            r.r = bk.r + scale255(sr.r - bk.r, op);
            r.g = bk.g + scale255(sr.g - bk.g, op);
            r.b = bk.b + scale255(sr.b - bk.b, op);
        end
        r.a = bk.a + scale255(sr.a - bk.a, op);
        if (r.a == 0)
        begin
            r.r = 0; r.g = 0; r.b = 0;
        end
        return r;
    endfunction

    function automatic int screen_ch(int b, int s);
        return b + s - scale255(b, s);
    endfunction

    function automatic int hard_ch(int b, int s);
        if (s < 128)
            return scale255(b, s * 2);
        return screen_ch(b, s * 2 - 255);
    endfunction

    function automatic int blend_channel(logic [4:0] mode, int b, int s);
        int v;
        case (mode)
            MODE_MULTIPLY:   return scale255(b, s);
            MODE_SCREEN:     return screen_ch(b, s);
            MODE_OVERLAY:    return hard_ch(s, b);
            MODE_DARKEN:     return b < s ? b : s;
            MODE_LIGHTEN:    return b > s ? b : s;
            MODE_DODGE:
            begin
                if (b == 0)
                    return 0;
                v = 255 - s;
                return b >= v ? 255 : ratio255(b, v);
            end
            MODE_BURN:
            begin
                if (b == 255)
                    return 255;
                v = 255 - b;
                return v >= s ? 0 : 255 - ratio255(v, s);
            end
            MODE_HARD_LIGHT: return hard_ch(b, s);
            MODE_DIFFERENCE: return b > s ? b - s : s - b;
            MODE_EXCLUSION:  return b + s - 2 * scale255(b, s);
            MODE_ADDITION:   return (b + s) > 255 ? 255 : b + s;
            MODE_SUBTRACT:   return (b - s) < 0 ? 0 : b - s;
            default:
            begin
                if (b == 0)
                    return 0;
                return b >= s ? 255 : ratio255(b, s);
            end
        endcase
    endfunction

    function automatic rgba_t separable_blend(logic [4:0] mode, rgba_t bk, rgba_t sr, int op);
        rgba_t m;
        m.r = blend_channel(mode, bk.r, sr.r);
        m.g = blend_channel(mode, bk.g, sr.g);
        m.b = blend_channel(mode, bk.b, sr.b);
        m.a = sr.a;
        return source_over(bk, m, op);
    endfunction

    function automatic out_word_t blended_pixel(in_word_t w);
        rgba_t bk;
        rgba_t sr;
        rgba_t r;
        rgba_t nrm;
        rgba_t bl;
        rgba_t mid;
        int op;
        out_word_t o;
        op = cur_opacity;
        bk = '{w.back_red, w.back_green, w.back_blue, w.back_alpha};
        sr = '{w.src_red, w.src_green, w.src_blue, w.src_alpha};
        if (cur_mode == MODE_SRC)
            r = sr;
        else if (cur_mode == MODE_MERGE)
            r = merge_pixels(bk, sr, op);
        else if (cur_mode == MODE_DST_OVER)
        begin
            // backdrop goes over the opacity-scaled source
            mid = sr;
            mid.a = scale255(sr.a, op);
            r = source_over(mid, bk, 255);
        end
        else if (cur_mode >= MODE_MULTIPLY && cur_mode <= MODE_DIVIDE)
        begin
            if (cur_new && bk.a != 0)
            begin
                nrm = source_over(bk, sr, op);
                bl = separable_blend(cur_mode, bk, sr, op);
                mid = merge_pixels(nrm, bl, bk.a);
                r = merge_pixels(mid, bl, scale255(bk.a, scale255(sr.a, op)));
            end
            else if (cur_new)
                r = source_over(bk, sr, op);
            else
                r = separable_blend(cur_mode, bk, sr, op);
        end
        else
            r = source_over(bk, sr, op);   // normal and unused codes
        o.out_red = r.r[7:0];
        o.out_green = r.g[7:0];
        o.out_blue = r.b[7:0];
        o.out_alpha = r.a[7:0];
        return o;
    endfunction

    // ------------------------------------------------------------ stimulus
    // mostly no gap, often a short one, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // valid stays high after the handshake so a zero gap runs back to back
    task automatic send_pixel(in_word_t w);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        pending_pixels.push_back(blended_pixel(w));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // no config write until the pipe has fully drained
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_BLEND_MODE:    cur_mode = val[4:0];
            REG_LAYER_OPACITY: cur_opacity = val;
            default:           cur_new = val[0];
        endcase
    endtask

    task automatic set_config(logic [4:0] mode, logic [7:0] op, logic nc);
        wait_drained();
        write_reg(REG_BLEND_MODE, {3'b000, mode});
        write_reg(REG_LAYER_OPACITY, op);
        write_reg(REG_NEW_COMPOSITE, {7'd0, nc});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic in_word_t rand_pixel();
        in_word_t w;
        int k;
        w = in_word_t'({$urandom, $urandom});
        // pull alphas toward the 0 / 255 special cases, or make them equal, a fair share of the time
        k = $urandom_range(0, 9);
        if (k == 0) w.back_alpha = 8'd0;
        if (k == 1) w.src_alpha = 8'd0;
        if (k == 2) w.back_alpha = 8'd255;
        if (k == 3) w.src_alpha = 8'd255;
        if (k == 4) w.back_alpha = w.src_alpha;
        return w;
    endfunction

    // transparent, opaque and mixed extremes; runs under the reset config
    task automatic test_directed_normal();
        send_pixel('{8'd10, 8'd20, 8'd30, 8'd0, 8'd200, 8'd100, 8'd50, 8'd128});
        send_pixel('{8'd10, 8'd20, 8'd30, 8'd90, 8'd200, 8'd100, 8'd50, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel('{8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd1});
        send_pixel('{8'd200, 8'd10, 8'd128, 8'd255, 8'd30, 8'd250, 8'd127, 8'd128});
    endtask

    // every mode once on a few edge pixels, both composite styles
    task automatic test_every_mode();
        for (int m = 0; m <= 17; m++)
        begin
            set_config(m[4:0], (m % 2) ? 8'd0 : 8'd255, m[0]);
            send_pixel('{8'd0, 8'd255, 8'd128, 8'd200, 8'd255, 8'd0, 8'd127, 8'd100});
            send_pixel('{8'd255, 8'd1, 8'd60, 8'd0, 8'd254, 8'd200, 8'd60, 8'd77});
        end
        set_config(5'd31, 8'd128, 1'b1);   // top unused code
        send_pixel('{8'd40, 8'd80, 8'd120, 8'd160, 8'd200, 8'd240, 8'd20, 8'd60});
    endtask

    task automatic test_random_blends();
        logic [4:0] m;
        logic [7:0] op;
        int p;
        for (int phase = 0; phase < 40; phase++)
        begin
            p = $urandom_range(0, 3);
            m = 5'((phase < 34) ? phase % 17 : $urandom_range(0, 31));
            op = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom_range(0, 255));
            set_config(m, op, 1'($urandom_range(0, 1)));
            repeat (50) send_pixel(rand_pixel());
        end
    endtask

    // hold off the sender until the output side has caught up, then burst
    task automatic test_full_drain();
        set_config(MODE_DIVIDE, 8'd200, 1'b1);
        repeat (20) send_pixel(rand_pixel());
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (20) send_pixel(rand_pixel());
    endtask

    // --------------------------------------------------------------- output
    // ready toggles at random, with an occasional long stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            stall_left <= $urandom_range(8, 30);
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) < 70);
    end

    // compare every accepted word against the oldest prediction
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", out_word);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (want !== out_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: want r%0d g%0d b%0d a%0d got r%0d g%0d b%0d a%0d",
                                 want.out_red, want.out_green, want.out_blue, want.out_alpha,
                                 out_word.out_red, out_word.out_green, out_word.out_blue,
                                 out_word.out_alpha);
                end
            end
        end
    end

    // watchdog: stalls without any accepted word on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("rgba_pixel_blend_unit_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_normal();
        test_every_mode();
        test_full_drain();
        test_random_blends();
        wait_drained();
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("rgba_pixel_blend_unit_top_tb: clean");
        else
            $display("rgba_pixel_blend_unit_top_tb: errors");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/rpbu_pkg.sv
rtl/rpbu_div.sv
rtl/rpbu_front.sv
rtl/rpbu_mid.sv
rtl/rpbu_back.sv
rtl/rgba_pixel_blend_unit_top.sv
tb/rgba_pixel_blend_unit_top_tb.sv
